>>> src/afr_pkg.sv
// Shared constants and types for the addressed frame receiver.
package afr_pkg;

    localparam int MaxFrameBytesDef = 16;
    localparam int CntW             = 7;
    localparam logic [7:0] OwnAddrRst = 8'd1;

    localparam logic [1:0] StData = 2'd0;
    localparam logic [1:0] StXor  = 2'd1;
    localparam logic [1:0] StOvf  = 2'd2;
    localparam logic [1:0] StLink = 2'd3;

    typedef struct packed {
        logic [1:0]      status;
        logic            bank;
        logic [CntW-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic vld;
        logic bank;
    } t_release;

endpackage

>>> src/afr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/afr_queue.sv
// Two-entry command queue between the front and back parts.
module afr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  afr_pkg::t_cmd i_push_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output afr_pkg::t_cmd o_head
);

    afr_pkg::t_cmd r_ent [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_fill,   n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + 2'd1;
            2'b01:   n_fill = r_fill - 2'd1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_head  = r_ent[r_rd_ptr];

endmodule

>>> src/afr_front.sv
// Front part: accepts received bytes, tracks the frame and stores payload.
module afr_front #(
    parameter int MAX_FRAME_BYTES = afr_pkg::MaxFrameBytesDef,
    parameter int IW              = $clog2(MAX_FRAME_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_rx_fault,
    input  logic              i_q_full,
    output logic              o_push,
    output afr_pkg::t_cmd     o_push_cmd,
    input  afr_pkg::t_release i_release,
    output logic              o_wr_en,
    output logic [IW:0]       o_wr_addr,
    output logic [7:0]        o_wr_data
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [1:0] PhWait = 2'd0;
    localparam logic [1:0] PhRecv = 2'd1;
    localparam logic [1:0] PhSkip = 2'd2;

    logic [7:0]    r_own_addr;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_xor,   n_xor;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic          r_bank,  n_bank;
    logic [1:0]    r_busy,  n_busy;
    logic          accept;
    logic          push;
    afr_pkg::t_cmd push_cmd;
    logic          wr_en;

    assign o_in_stall = i_q_full || r_busy[r_bank];
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_phase  = r_phase;
        n_xor    = r_xor;
        n_cnt    = r_cnt;
        n_bank   = r_bank;
        n_busy   = r_busy;
        push     = 1'b0;
        push_cmd = '{status: afr_pkg::StData, bank: r_bank,
                     count: afr_pkg::CntW'(r_cnt)};
        wr_en    = 1'b0;
        if (i_release.vld) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            if (i_rx_fault) begin
                push            = 1'b1;
                push_cmd.status = afr_pkg::StLink;
                n_phase         = PhWait;
                n_xor           = 8'd0;
                n_cnt           = '0;
            end else begin
                unique case (r_phase)
                    PhWait: begin
                        if (i_rx_byte != 8'd0) begin
                            if (i_rx_byte == r_own_addr) begin
                                n_phase = PhRecv;
                                n_xor   = i_rx_byte;
                                n_cnt   = '0;
                            end else begin
                                n_phase = PhSkip;
                            end
                        end
                    end
                    PhRecv: begin
                        if (i_rx_byte == 8'd0) begin
                            push = 1'b1;
                            if (r_xor != 8'd0 || r_cnt == '0) begin
                                push_cmd.status = afr_pkg::StXor;
                            end else begin
                                n_busy[r_bank] = 1'b1;
                                n_bank         = ~r_bank;
                            end
                            n_phase = PhWait;
                            n_xor   = 8'd0;
                            n_cnt   = '0;
                        end else if (r_cnt >= CW'(MAX_FRAME_BYTES)) begin
                            push            = 1'b1;
                            push_cmd.status = afr_pkg::StOvf;
                            n_phase         = PhSkip;
                            n_xor           = 8'd0;
                            n_cnt           = '0;
                        end else begin
                            wr_en = 1'b1;
                            n_cnt = r_cnt + CW'(1);
                            n_xor = r_xor ^ i_rx_byte;
                        end
                    end
                    default: begin
                        if (i_rx_byte == 8'd0) begin
                            n_phase = PhWait;
                            n_xor   = 8'd0;
                            n_cnt   = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= afr_pkg::OwnAddrRst;
            r_phase    <= PhWait;
            r_xor      <= 8'd0;
            r_cnt      <= '0;
            r_bank     <= 1'b0;
            r_busy     <= 2'b00;
        end else begin
            if (i_cfg_wr_en) begin
                r_own_addr <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_cnt   <= n_cnt;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

    assign o_push     = push;
    assign o_push_cmd = push_cmd;
    assign o_wr_en    = wr_en;
    assign o_wr_addr  = {r_bank, r_cnt[IW-1:0]};
    assign o_wr_data  = i_rx_byte;

endmodule

>>> src/afr_back.sv
// Back part: turns queued commands into result transactions.
module afr_back #(
    parameter int MAX_FRAME_BYTES = afr_pkg::MaxFrameBytesDef,
    parameter int IW              = $clog2(MAX_FRAME_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  afr_pkg::t_cmd     i_q_head,
    output logic              o_pop,
    output logic [IW:0]       o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output afr_pkg::t_release o_release,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [7:0]        o_data_byte,
    output logic              o_last
);

    localparam logic SIdle  = 1'b0;
    localparam logic SDrain = 1'b1;

    logic                     r_state, n_state;
    logic                     r_bank,  n_bank;
    logic [afr_pkg::CntW-1:0] r_cnt,   n_cnt;
    logic [afr_pkg::CntW-1:0] r_idx,   n_idx;
    logic                     r_o_valid, n_o_valid;
    logic [1:0]               r_o_status, n_o_status;
    logic [7:0]               r_o_data,   n_o_data;
    logic                     r_o_last,   n_o_last;
    logic                     out_free;
    logic                     pop;
    logic                     last_byte;
    afr_pkg::t_release        release_s;

    assign out_free  = !r_o_valid || !i_out_stall;
    assign last_byte = ((r_idx + afr_pkg::CntW'(1)) == r_cnt);

    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_status = r_o_status;
        n_o_data   = r_o_data;
        n_o_last   = r_o_last;
        pop        = 1'b0;
        release_s  = '{vld: 1'b0, bank: r_bank};
        unique case (r_state)
            SIdle: begin
                if (!i_q_empty && out_free) begin
                    pop = 1'b1;
                    if (i_q_head.status == afr_pkg::StData) begin
                        n_state = SDrain;
                        n_bank  = i_q_head.bank;
                        n_cnt   = i_q_head.count;
                        n_idx   = '0;
                    end else begin
                        n_o_valid  = 1'b1;
                        n_o_status = i_q_head.status;
                        n_o_data   = 8'd0;
                        n_o_last   = 1'b1;
                    end
                end
            end
            default: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = afr_pkg::StData;
                    n_o_data   = i_rd_data;
                    n_o_last   = last_byte;
                    n_idx      = r_idx + afr_pkg::CntW'(1);
                    if (last_byte) begin
                        n_state       = SIdle;
                        release_s.vld = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SIdle;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank     <= n_bank;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
        r_o_last   <= n_o_last;
    end

    assign o_pop       = pop;
    assign o_rd_addr   = {n_bank, n_idx[IW-1:0]};
    assign o_release   = release_s;
    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_data_byte = r_o_data;
    assign o_last      = r_o_last;

endmodule

>>> src/addressed_frame_receiver_xor_check.sv
// Top level of the addressed frame receiver with XOR check.
//
// Input channel: one received byte and a link fault flag per transaction
// (i_in_valid / o_in_stall). Output channel: one result per transaction
// (o_out_valid / i_out_stall) with status, data byte and last mark.
// i_cfg_wr_en with i_cfg_wr_data sets the own address (reset value 1).
// A good frame is stored in one of two RAM banks; at its terminator a drain
// command is queued and the back part reads the bank out, one byte per
// cycle while the result register is free, so a frame of N stored bytes
// yields N results; each byte passes through the RAM read register and then
// the result register. Error results pass through the command queue and
// then the result register.
// Bytes are taken one per cycle while the command queue has room and the
// current RAM bank is not still being read out; o_in_stall rises otherwise.
// While the receiver holds i_out_stall the result register holds, the back
// part waits, and the front part keeps taking bytes until o_in_stall rises.
// Reset returns to waiting for an address with an empty queue; no RAM
// clearing pass is needed.
module addressed_frame_receiver_xor_check #(
    parameter int MAX_FRAME_BYTES = afr_pkg::MaxFrameBytesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_rx_fault,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_data_byte,
    output logic       o_last
);

    localparam int IW       = $clog2(MAX_FRAME_BYTES);
    localparam int RamDepth = 2 ** (IW + 1);

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    afr_pkg::t_cmd     push_cmd;
    afr_pkg::t_cmd     q_head;
    afr_pkg::t_release rel;
    logic              wr_en;
    logic [IW:0]       wr_addr;
    logic [7:0]        wr_data;
    logic [IW:0]       rd_addr;
    logic [7:0]        rd_data;

    afr_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .IW              (IW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .i_rx_fault    (i_rx_fault),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_push_cmd    (push_cmd),
        .i_release     (rel),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    afr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (push_cmd),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    afr_ram #(
        .WIDTH (8),
        .DEPTH (RamDepth)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    afr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .IW              (IW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_release   (rel),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    a_error_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != afr_pkg::StData) |-> (o_last && o_data_byte == 8'd0))
        else $error("error result without last mark or with data");

    a_no_write_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !q_empty) |-> (q_head.status != afr_pkg::StData
            || q_head.bank != wr_addr[IW]))
        else $error("payload write into bank queued for readout");

endmodule
